>>> rtl/obx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obx_pkg
// Types, constants and helpers shared by the oriented box extent fit unit.
// ----------------------------------------------------------------------------
package obx_pkg;

    localparam int NUM_AXES  = 6;
    localparam int NUM_COMP  = 3;
    localparam int CORNERS   = 16;

    typedef logic signed [17:0] t_coord;   // input point coordinate
    typedef logic signed [15:0] t_comp;    // Q1.14 axis component
    typedef logic        [47:0] t_axis;    // packed x,y,z components
    typedef logic signed [23:0] t_ext;     // projection / corner coordinate

    localparam t_ext EXT_MAX = 24'sh7FFFFF;
    localparam t_ext EXT_MIN = -24'sh800000;
    localparam logic [2:0] IDX_LIMIT = 3'd6;     // register indexes 0..5 are valid

    typedef struct packed {
        t_ext [NUM_AXES-1:0] mn;
        t_ext [NUM_AXES-1:0] mx;
    } t_extents;

    // component c (0 x, 1 y, 2 z) of a packed axis
    function automatic t_comp axis_comp(input t_axis v, input int c);
        axis_comp = $signed(v[16*c +: 16]);
    endfunction

    // per corner: which of u, v, w take the maximum (bit0 u, bit1 v, bit2 w)
    function automatic logic [2:0] corner_mask(input logic [2:0] k);
        logic [2:0] m;
        case (k)
            3'd0:    m = 3'd0;
            3'd1:    m = 3'd1;
            3'd2:    m = 3'd3;
            3'd3:    m = 3'd2;
            3'd4:    m = 3'd6;
            3'd5:    m = 3'd4;
            3'd6:    m = 3'd5;
            default: m = 3'd7;
        endcase
        corner_mask = m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/obx_corner_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obx_corner_gen
// Holds one captured pair of boxes and walks their sixteen corners out
// through a multiply stage and a round/saturate output register.
// ----------------------------------------------------------------------------
module obx_corner_gen
    import obx_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire t_extents             i_ext,
    input  wire t_axis [NUM_AXES-1:0] i_frame,
    output logic                      o_busy,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [71:0]               o_data,   // cx, cy, cz
    output logic [7:0]                o_user,   // frame_sel, corner_idx, zero pad
    output logic                      o_last
);

    t_extents          r_box;
    logic              r_busy;
    logic [3:0]        r_cnt;

    logic              r_a_valid;
    logic              r_a_fsel;
    logic [2:0]        r_a_idx;
    logic              r_a_last;
    logic signed [39:0] r_a_prod [NUM_COMP][NUM_COMP];

    logic              r_o_valid;
    logic [71:0]       r_o_data;
    logic [7:0]        r_o_user;
    logic              r_o_last;

    logic              out_adv;
    logic              a_adv;
    logic              issue;
    logic [2:0]        mask;
    logic signed [39:0] n_prod [NUM_COMP][NUM_COMP];
    logic [71:0]       n_data;

    assign out_adv = !r_o_valid || i_ready;
    assign a_adv   = !r_a_valid || out_adv;
    assign issue   = r_busy && a_adv;
    assign mask    = corner_mask(r_cnt[2:0]);

    always_comb begin
        logic [2:0] ax;
        t_ext       e;
        for (int c = 0; c < NUM_COMP; c++) begin
            for (int j = 0; j < NUM_COMP; j++) begin
                ax = 3'(j) + (r_cnt[3] ? 3'd3 : 3'd0);
                e  = mask[j] ? $signed(r_box.mx[ax]) : $signed(r_box.mn[ax]);
                n_prod[c][j] = $signed(e) * $signed(axis_comp(i_frame[ax], c));
            end
        end
    end

    always_comb begin
        logic signed [41:0] s;
        logic signed [27:0] r;
        for (int c = 0; c < NUM_COMP; c++) begin
            s = 42'(r_a_prod[c][0]) + 42'(r_a_prod[c][1]) + 42'(r_a_prod[c][2])
                + 42'sd8192;
            r = s[41:14];
            if (r > 28'(EXT_MAX))
                n_data[24*c +: 24] = EXT_MAX;
            else if (r < 28'(EXT_MIN))
                n_data[24*c +: 24] = EXT_MIN;
            else
                n_data[24*c +: 24] = r[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd0;
        end else if (issue) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'(CORNERS - 1))
                r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load)
            r_box <= i_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_adv) begin
            r_a_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_fsel <= r_cnt[3];
            r_a_idx  <= r_cnt[2:0];
            r_a_last <= (r_cnt == 4'(CORNERS - 1));
            r_a_prod <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_a_valid) begin
            r_o_data <= n_data;
            r_o_user <= {4'd0, r_a_idx, r_a_fsel};
            r_o_last <= r_a_last;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_user  = r_o_user;
    assign o_last  = r_o_last;

    // a capture never lands on a run still being walked
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy)
        else $error("box captured while corners pending");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && r_cnt == 4'(CORNERS - 1)) |=> !r_busy)
        else $error("corner walk did not end after last corner");

    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> (r_o_user[3:0] == 4'hF))
        else $error("end of run flagged on wrong corner");

endmodule
`default_nettype wire

>>> rtl/oriented_box_extent_fit_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oriented_box_extent_fit_unit
// Streams points, tracks min/max of their projections on two frames and
// emits the sixteen oriented box corners on the last point of each run.
// ----------------------------------------------------------------------------
// One point word is taken every cycle while s_axis_tready is high. A point
// passes a product register (eighteen 18x16 products) and then updates the
// six min/max extents. On a word with tlast the final extents are handed to
// the corner unit and cleared; that unit sends the sixteen corners (frame
// one p0..p7, then frame two p0..p7), one per cycle when the sink takes
// them, each through its multiply stage and round/saturate output register.
// A further last point reaching the extent stage before the corner unit has
// issued all sixteen corners holds s_axis_tready low until it has. The user
// must write frame registers through the cfg channel only while idle; the
// block itself does not enforce it.
module oriented_box_extent_fit_unit
    import obx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // px, py, pz, zero pad
    input  wire logic        s_axis_tlast,   // final_point
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // cx, cy, cz
    output logic [7:0]       m_axis_tuser,   // frame_sel, corner_idx, zero pad
    output logic             m_axis_tlast    // end_of_run
);

    t_axis [NUM_AXES-1:0] r_frame;

    logic               r_s1_valid;
    logic               r_s1_last;
    logic signed [33:0] r_s1_prod [NUM_AXES][NUM_COMP];

    t_extents           r_ext;
    t_extents           n_ext;

    logic               busy;
    logic               s1_adv;
    logic               in_acc;
    logic               load;
    t_coord             pt [NUM_COMP];
    logic signed [33:0] n_prod [NUM_AXES][NUM_COMP];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_cfg_valid && i_cfg_index < IDX_LIMIT) begin
            r_frame[i_cfg_index] <= i_cfg_data;
        end
    end

    // a final point waits while the previous run is still being walked
    assign s1_adv        = !(r_s1_last && busy);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load          = r_s1_valid && r_s1_last && !busy;

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++)
            pt[c] = $signed(s_axis_tdata[18*c +: 18]);
        for (int a = 0; a < NUM_AXES; a++)
            for (int c = 0; c < NUM_COMP; c++)
                n_prod[a][c] = $signed(pt[c]) * $signed(axis_comp(r_frame[a], c));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_last <= 1'b0;
        end else if (in_acc) begin
            r_s1_last <= s_axis_tlast;
        end else if (s_axis_tready) begin
            r_s1_last <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_s1_prod <= n_prod;
    end

    // round half up to integer, then fold into the running extents
    always_comb begin
        logic signed [35:0] s;
        t_ext               pr;
        for (int a = 0; a < NUM_AXES; a++) begin
            s  = 36'(r_s1_prod[a][0]) + 36'(r_s1_prod[a][1]) + 36'(r_s1_prod[a][2])
                 + 36'sd8192;
            pr = 24'($signed(s[35:14]));
            n_ext.mn[a] = (pr < $signed(r_ext.mn[a])) ? pr : r_ext.mn[a];
            n_ext.mx[a] = (pr > $signed(r_ext.mx[a])) ? pr : r_ext.mx[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_ext.mn[a] <= EXT_MAX;
                r_ext.mx[a] <= EXT_MIN;
            end
        end else if (r_s1_valid && s1_adv) begin
            if (r_s1_last) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_ext.mn[a] <= EXT_MAX;
                    r_ext.mx[a] <= EXT_MIN;
                end
            end else begin
                r_ext <= n_ext;
            end
        end
    end

    obx_corner_gen u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_ext   (n_ext),
        .i_frame (r_frame),
        .o_busy  (busy),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire
